[hw/rtl/tpsi_pkg.sv]
// Shared constants, control word layout and the microcode table of the strip index generator.
package tpsi_pkg;

    // Limits
    localparam int MAX_MAP_SIDE    = 4096;
    localparam int MAX_PATCH_VERTS = 31;

    // Field widths
    localparam int MAP_W      = 13;
    localparam int PATCH_W    = 9;
    localparam int STEP_W     = 5;
    localparam int COORD_W    = 12;
    localparam int COL_W      = 5;
    localparam int IDX_W      = 24;
    localparam int ROWS_W     = 5;
    localparam int SPAN_W     = 10;
    localparam int X_W        = COORD_W + 1;
    localparam int Z_W        = COORD_W + 1;
    localparam int CNT_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAP_SIDE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATCH_SIDE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_STEP = 2'd2;

    localparam logic [MAP_W-1:0]   MAP_SIDE_RESET    = 13'd257;
    localparam logic [PATCH_W-1:0] PATCH_SIDE_RESET  = 9'd17;
    localparam logic [STEP_W-1:0]  VERTEX_STEP_RESET = 5'd1;

    // Program counter values
    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] PC_WAIT = 4'd0;
    localparam logic [PC_W-1:0] PC_PREP = 4'd1;
    localparam logic [PC_W-1:0] PC_DIV  = 4'd2;
    localparam logic [PC_W-1:0] PC_ROWS = 4'd3;
    localparam logic [PC_W-1:0] PC_CHK  = 4'd4;
    localparam logic [PC_W-1:0] PC_BASE = 4'd5;
    localparam logic [PC_W-1:0] PC_DEG0 = 4'd6;
    localparam logic [PC_W-1:0] PC_DEG1 = 4'd7;
    localparam logic [PC_W-1:0] PC_ROW0 = 4'd8;
    localparam logic [PC_W-1:0] PC_ROW1 = 4'd9;
    localparam logic [PC_W-1:0] PC_BAD  = 4'd10;

    // Datapath operations
    localparam logic [2:0] OP_NONE    = 3'd0;
    localparam logic [2:0] OP_LOAD    = 3'd1;
    localparam logic [2:0] OP_PREP    = 3'd2;
    localparam logic [2:0] OP_DIV     = 3'd3;
    localparam logic [2:0] OP_ROWS    = 3'd4;
    localparam logic [2:0] OP_ZSTART  = 3'd5;
    localparam logic [2:0] OP_BASE    = 3'd6;
    localparam logic [2:0] OP_ADVANCE = 3'd7;

    // Emitted value select
    localparam logic [1:0] SEL_BASE  = 2'd0;
    localparam logic [1:0] SEL_LEAD  = 2'd1;
    localparam logic [1:0] SEL_TRAIL = 2'd2;
    localparam logic [1:0] SEL_BAD   = 2'd3;

    // Last flag select
    localparam logic [1:0] LAST_NEVER  = 2'd0;
    localparam logic [1:0] LAST_ROW    = 2'd1;
    localparam logic [1:0] LAST_ALWAYS = 2'd2;

    // Jump conditions
    localparam logic [2:0] JC_NEVER    = 3'd0;
    localparam logic [2:0] JC_DIV_MORE = 3'd1;
    localparam logic [2:0] JC_BAD      = 3'd2;
    localparam logic [2:0] JC_COL0     = 3'd3;
    localparam logic [2:0] JC_LAST_ROW = 3'd4;

    typedef struct packed {
        logic            in_rdy;
        logic            emit;
        logic [2:0]      op;
        logic [1:0]      sel;
        logic [1:0]      lsel;
        logic [2:0]      cond;
        logic [PC_W-1:0] jt;
        logic [PC_W-1:0] jf;
    } cw_t;

    typedef struct packed {
        logic div_more;
        logic bad;
        logic col0;
        logic last_row;
        logic out_free;
    } flags_t;

    function automatic cw_t ucode(input logic [PC_W-1:0] pc);
        cw_t cw;
        cw = '0;
        case (pc)
            PC_WAIT:
            begin
                cw.in_rdy = 1'b1;
                cw.op     = OP_LOAD;
                cw.jf     = PC_PREP;
            end
            PC_PREP:
            begin
                cw.op = OP_PREP;
                cw.jf = PC_DIV;
            end
            PC_DIV:
            begin
                cw.op   = OP_DIV;
                cw.cond = JC_DIV_MORE;
                cw.jt   = PC_DIV;
                cw.jf   = PC_ROWS;
            end
            PC_ROWS:
            begin
                cw.op = OP_ROWS;
                cw.jf = PC_CHK;
            end
            PC_CHK:
            begin
                cw.op   = OP_ZSTART;
                cw.cond = JC_BAD;
                cw.jt   = PC_BAD;
                cw.jf   = PC_BASE;
            end
            PC_BASE:
            begin
                cw.op   = OP_BASE;
                cw.cond = JC_COL0;
                cw.jt   = PC_ROW0;
                cw.jf   = PC_DEG0;
            end
            PC_DEG0:
            begin
                cw.emit = 1'b1;
                cw.sel  = SEL_BASE;
                cw.jf   = PC_DEG1;
            end
            PC_DEG1:
            begin
                cw.emit = 1'b1;
                cw.sel  = SEL_BASE;
                cw.jf   = PC_ROW0;
            end
            PC_ROW0:
            begin
                cw.emit = 1'b1;
                cw.sel  = SEL_LEAD;
                cw.jf   = PC_ROW1;
            end
            PC_ROW1:
            begin
                cw.emit = 1'b1;
                cw.sel  = SEL_TRAIL;
                cw.lsel = LAST_ROW;
                cw.op   = OP_ADVANCE;
                cw.cond = JC_LAST_ROW;
                cw.jt   = PC_WAIT;
                cw.jf   = PC_ROW0;
            end
            PC_BAD:
            begin
                cw.emit = 1'b1;
                cw.sel  = SEL_BAD;
                cw.lsel = LAST_ALWAYS;
                cw.jf   = PC_WAIT;
            end
            default:
            begin
                cw.jf = PC_WAIT;
            end
        endcase
        return cw;
    endfunction

endpackage

[hw/rtl/tpsi_if.sv]
// Request and result channel interfaces of the strip index generator.
interface tpsi_req_if import tpsi_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_z;
    logic [COL_W-1:0]   column;

    modport source (output valid, output origin_x, output origin_z, output column, input ready);
    modport sink (input valid, input origin_x, input origin_z, input column, output ready);
endinterface

interface tpsi_rsp_if import tpsi_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] vertex_index;
    logic             last;
    logic             bad_column;

    modport source (output valid, output vertex_index, output last, output bad_column,
                    input ready);
    modport sink (input valid, input vertex_index, input last, input bad_column,
                  output ready);
endinterface

[hw/rtl/terrain_patch_strip_indices.sv]
// Top level of the terrain patch strip index generator: register file and channel wiring.
//
// Usage
//   req  : one transfer per column request (origin_x, origin_z, column).
//   rsp  : the column's triangle-strip vertex indices, one transfer each; last marks
//          the final index, bad_column flags a single result for a column past the patch.
//   cfg  : cfg_we writes cfg_data to register cfg_index (0 map_side, 1 patch_side,
//          2 vertex_step); write only while no request is in flight.
// Timing
//   A request is worked on one at a time by a microcoded sequencer. After the request
//   transfer come 1 prep step, 9 divider steps (one quotient bit each) for the row
//   count, and 3 setup steps, then one index per cycle while rsp does not stall:
//   2*rows indices plus 2 stitching indices for every column but column 0. The next
//   request is taken once the last index has been loaded into the output register.
// Reset clears the step counter and the output valid and loads map_side 257,
// patch_side 17 and vertex_step 1. When rsp stalls, the output register holds its
// index and the sequencer waits on the emitting step.
module terrain_patch_strip_indices import tpsi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    tpsi_req_if.sink              req,
    tpsi_rsp_if.source            rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [MAP_W-1:0]   map_side_reg;
    logic [PATCH_W-1:0] patch_side_reg;
    logic [STEP_W-1:0]  vertex_step_reg;
    cw_t                cw;
    logic               go;
    flags_t             flags;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_side_reg    <= MAP_SIDE_RESET;
            patch_side_reg  <= PATCH_SIDE_RESET;
            vertex_step_reg <= VERTEX_STEP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAP_SIDE:
                begin
                    // Saturate at the largest supported grid
                    map_side_reg <= (cfg_data > CFG_DATA_W'(MAX_MAP_SIDE))
                                    ? MAP_W'(MAX_MAP_SIDE) : MAP_W'(cfg_data);
                end
                REG_PATCH_SIDE:
                begin
                    patch_side_reg <= cfg_data[PATCH_W-1:0];
                end
                REG_VERTEX_STEP:
                begin
                    vertex_step_reg <= cfg_data[STEP_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    tpsi_sequencer u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .flags    (flags),
        .cw       (cw),
        .go       (go)
    );

    tpsi_datapath u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cw          (cw),
        .go          (go),
        .map_side    (map_side_reg),
        .patch_side  (patch_side_reg),
        .vertex_step (vertex_step_reg),
        .origin_x    (req.origin_x),
        .origin_z    (req.origin_z),
        .column      (req.column),
        .out_ready   (rsp.ready),
        .flags       (flags),
        .out_valid   (rsp.valid),
        .out_index   (rsp.vertex_index),
        .out_last    (rsp.last),
        .out_bad     (rsp.bad_column)
    );

    assign req.ready = cw.in_rdy;

endmodule

[hw/rtl/tpsi_sequencer.sv]
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module tpsi_sequencer import tpsi_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  flags_t flags,
    output cw_t    cw,
    output logic   go
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            take;

    assign cw = ucode(pc_reg);

    // Hold the step while waiting for a request or for room in the output register
    assign go = (!cw.in_rdy || in_valid) && (!cw.emit || flags.out_free);

    always_comb
    begin
        case (cw.cond)
            JC_DIV_MORE: take = flags.div_more;
            JC_BAD:      take = flags.bad;
            JC_COL0:     take = flags.col0;
            JC_LAST_ROW: take = flags.last_row;
            default:     take = 1'b0;
        endcase
    end

    always_comb
    begin
        pc_next = pc_reg;
        if (go)
        begin
            pc_next = take ? cw.jt : cw.jf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    a_accept_then_prep: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && cw.in_rdy) |=> (pc_reg == PC_PREP))
        else $error("request transfer not followed by prep step");

    a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= PC_BAD)
        else $error("step counter outside program");

    a_ready_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        cw.in_rdy |-> (pc_reg == PC_WAIT))
        else $error("request ready outside wait step");

endmodule

[hw/rtl/tpsi_datapath.sv]
// Datapath: request registers, row-count divider, index accumulator and output register.
module tpsi_datapath import tpsi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cw_t                cw,
    input  logic               go,
    input  logic [MAP_W-1:0]   map_side,
    input  logic [PATCH_W-1:0] patch_side,
    input  logic [STEP_W-1:0]  vertex_step,
    input  logic [COORD_W-1:0] origin_x,
    input  logic [COORD_W-1:0] origin_z,
    input  logic [COL_W-1:0]   column,
    input  logic               out_ready,
    output flags_t             flags,
    output logic               out_valid,
    output logic [IDX_W-1:0]   out_index,
    output logic               out_last,
    output logic               out_bad
);

    logic [COORD_W-1:0]       ox_reg;
    logic [COORD_W-1:0]       oz_reg;
    logic [COL_W-1:0]         col_reg;
    logic [STEP_W-1:0]        step_reg;
    logic [PATCH_W-1:0]       span_reg;
    logic [X_W-1:0]           x_reg;
    logic [STEP_W-1:0]        rem_reg;
    logic [PATCH_W-1:0]       dvd_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [ROWS_W-1:0]        rows_reg;
    logic [SPAN_W-1:0]        span_eff_reg;
    logic [STEP_W+MAP_W-1:0]  delta_reg;
    logic [Z_W-1:0]           zstart_reg;
    logic [IDX_W-1:0]         base_reg;
    logic [ROWS_W-1:0]        k_reg;
    logic                     out_valid_reg;
    logic [IDX_W-1:0]         out_index_reg;
    logic                     out_last_reg;
    logic                     out_bad_reg;

    logic [STEP_W-1:0]        step_eff;
    logic [PATCH_W-1:0]       span_in;
    logic [2*STEP_W-1:0]      col_off;
    logic [STEP_W:0]          trial;
    logic                     trial_ge;
    logic                     capped;
    logic [STEP_W+MAP_W-1:0]  delta_prod;
    logic [Z_W+MAP_W-1:0]     base_prod;
    logic [IDX_W-1:0]         base_plus;
    logic [IDX_W-1:0]         emit_value;
    logic                     emit_last;
    logic                     emit_fire;

    assign step_eff = (vertex_step == '0) ? STEP_W'(1) : vertex_step;
    assign span_in  = (patch_side < PATCH_W'(2)) ? '0 : patch_side - PATCH_W'(1);
    assign col_off  = (2*STEP_W)'(col_reg) * (2*STEP_W)'(step_eff);

    // One restoring division step: shift a dividend bit into the remainder
    assign trial    = {rem_reg, dvd_reg[PATCH_W-1]};
    assign trial_ge = trial >= {1'b0, step_reg};

    assign capped     = dvd_reg >= PATCH_W'(MAX_PATCH_VERTS);
    assign delta_prod = (STEP_W+MAP_W)'(step_reg) * (STEP_W+MAP_W)'(map_side);
    assign base_prod  = (Z_W+MAP_W)'(zstart_reg) * (Z_W+MAP_W)'(map_side);
    assign base_plus  = base_reg + IDX_W'(step_reg);

    assign flags.div_more = cnt_reg != CNT_W'(1);
    assign flags.bad      = ({1'b0, col_reg} + (COL_W+1)'(1)) >= {1'b0, rows_reg};
    assign flags.col0     = col_reg == '0;
    assign flags.last_row = k_reg == (rows_reg - ROWS_W'(1));
    assign flags.out_free = !out_valid_reg || out_ready;

    assign emit_fire = go && cw.emit;

    // Even columns lead with the right-hand vertex, odd columns with the left
    always_comb
    begin
        case (cw.sel)
            SEL_BASE:  emit_value = base_reg;
            SEL_LEAD:  emit_value = col_reg[0] ? base_reg : base_plus;
            SEL_TRAIL: emit_value = col_reg[0] ? base_plus : base_reg;
            default:   emit_value = '0;
        endcase
    end

    always_comb
    begin
        case (cw.lsel)
            LAST_ROW:    emit_last = flags.last_row;
            LAST_ALWAYS: emit_last = 1'b1;
            default:     emit_last = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            case (cw.op)
                OP_LOAD:
                begin
                    ox_reg  <= origin_x;
                    oz_reg  <= origin_z;
                    col_reg <= column;
                end
                OP_PREP:
                begin
                    step_reg <= step_eff;
                    span_reg <= span_in;
                    x_reg    <= X_W'(ox_reg) + X_W'(col_off);
                    rem_reg  <= '0;
                    dvd_reg  <= span_in;
                    cnt_reg  <= CNT_W'(PATCH_W);
                end
                OP_DIV:
                begin
                    rem_reg <= trial_ge ? STEP_W'(trial - {1'b0, step_reg}) : trial[STEP_W-1:0];
                    dvd_reg <= {dvd_reg[PATCH_W-2:0], trial_ge};
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
                OP_ROWS:
                begin
                    rows_reg     <= capped ? ROWS_W'(MAX_PATCH_VERTS)
                                           : ROWS_W'(dvd_reg + PATCH_W'(1));
                    span_eff_reg <= capped ? SPAN_W'(step_reg) * SPAN_W'(MAX_PATCH_VERTS - 1)
                                           : SPAN_W'(span_reg);
                    delta_reg    <= delta_prod;
                end
                OP_ZSTART:
                begin
                    zstart_reg <= col_reg[0] ? Z_W'(oz_reg) + Z_W'(span_eff_reg) : Z_W'(oz_reg);
                end
                OP_BASE:
                begin
                    base_reg <= IDX_W'(base_prod) + IDX_W'(x_reg);
                    k_reg    <= '0;
                end
                OP_ADVANCE:
                begin
                    base_reg <= col_reg[0] ? base_reg - IDX_W'(delta_reg)
                                           : base_reg + IDX_W'(delta_reg);
                    k_reg    <= k_reg + ROWS_W'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_index_reg <= emit_value;
            out_last_reg  <= emit_last;
            out_bad_reg   <= cw.sel == SEL_BAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_last  = out_last_reg;
    assign out_bad   = out_bad_reg;

    a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_bad_reg) |-> out_last_reg)
        else $error("flagged result without last");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && cw.sel == SEL_TRAIL) |-> (k_reg < rows_reg))
        else $error("row counter past row count");

    a_rows_range: assert property (@(posedge clk) disable iff (!rst_n)
        (go && cw.op == OP_ROWS) |=>
            (rows_reg != '0 && rows_reg <= ROWS_W'(MAX_PATCH_VERTS)))
        else $error("row count out of range");

endmodule
